>>> hw/rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants of the PS/2 mouse packet tracker
// Holds the register map, the reset values, the configuration and result
// structures and the packet phase encoding.
// ----------------------------------------------------------------------------
package pmt_pkg;

	// Fixed widths of the interface fields
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = 12;
	localparam int OUT_W   = 12;
	localparam int BTN_W   = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 2;

	// Register indexes (byte address is four times the index)
	localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_X_MAX  = 2'd1;
	localparam logic [IDX_W-1:0] REG_Y_MAX  = 2'd2;

	// Reset values
	localparam logic [LIMIT_W-1:0] X_MAX_RESET = 12'd319;
	localparam logic [LIMIT_W-1:0] Y_MAX_RESET = 12'd199;
	localparam int                 POS_X_RESET = 160;
	localparam int                 POS_Y_RESET = 100;
	localparam logic [BYTE_W-1:0]  BTN_MASK    = 8'h07;

	typedef struct packed {
		logic               enable;
		logic [LIMIT_W-1:0] x_max;
		logic [LIMIT_W-1:0] y_max;
	} cfg_t;

	typedef struct packed {
		logic             packet_done;
		logic [OUT_W-1:0] cursor_x;
		logic [OUT_W-1:0] cursor_y;
		logic [BTN_W-1:0] button_bits;
	} res_t;

	typedef enum logic [2:0] {
		PH_FLAGS = 3'b001,
		PH_DX    = 3'b010,
		PH_DY    = 3'b100
	} phase_t;

endpackage

>>> hw/rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker: PS/2 mouse packet tracker
// Groups mouse bytes into three-byte packets and keeps a clamped cursor
// position and the button state.
// ----------------------------------------------------------------------------
// Each byte transfer on the input channel produces exactly one result transfer
// on the output channel, in order. A byte is taken into an input register;
// as it leaves that register the packet logic updates the phase, the cursor
// and the buttons and loads the result register, and one byte can be taken
// every cycle while the result side does not stall. When the result
// register is held by a stall, the input register keeps its byte and
// in_stall rises only once both registers are full. Every third byte
// after enable completes a packet: dx is added to cursor_x and dy subtracted
// from cursor_y (screen Y grows downward), both are clamped to zero and to
// the x_max and y_max registers, and the low three flag bits become the
// buttons. While enable is low, bytes are still answered, with packet_done
// low and the position unchanged. Registers sit at byte addresses 0 (enable),
// 4 (x_max) and 8 (y_max) of the APB-style port; the user must write them only
// while no transfer is in flight; the block does not enforce this. COORD_BITS
// sets the width of the stored position, and the limits are further capped to what that width can hold.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
	parameter int COORD_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pmt_pkg::ADDR_W-1:0]  paddr,
	input  logic [pmt_pkg::DATA_W-1:0]  pwdata,
	output logic [pmt_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// byte input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pmt_pkg::BYTE_W-1:0]  data_byte,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        packet_done,
	output logic [pmt_pkg::OUT_W-1:0]   cursor_x,
	output logic [pmt_pkg::OUT_W-1:0]   cursor_y,
	output logic [pmt_pkg::BTN_W-1:0]   button_bits
);
	import pmt_pkg::*;

	cfg_t              cfg;
	res_t              res;
	res_t              res_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              out_valid_q;
	logic              advance;

	pmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The byte in the input register moves on whenever the result register
	// is empty or its result is being taken in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) data_s1 <= data_byte;
	end

	// The packet state is updated exactly once per byte, as it leaves the
	// input register.
	pmt_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (data_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign packet_done = res_q.packet_done;
	assign cursor_x    = res_q.cursor_x;
	assign cursor_y    = res_q.cursor_y;
	assign button_bits = res_q.button_bits;

endmodule

>>> hw/rtl/pmt_cfg.sv
// ----------------------------------------------------------------------------
// pmt_cfg: configuration registers
// APB-style register file holding the enable bit and the two clamp limits.
// ----------------------------------------------------------------------------
module pmt_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pmt_pkg::ADDR_W-1:0]  paddr,
	input  logic [pmt_pkg::DATA_W-1:0]  pwdata,
	output logic [pmt_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pmt_pkg::cfg_t               cfg
);
	import pmt_pkg::*;

	logic             enable_q;
	logic [LIMIT_W-1:0] x_max_q;
	logic [LIMIT_W-1:0] y_max_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			x_max_q  <= X_MAX_RESET;
			y_max_q  <= Y_MAX_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_X_MAX:  x_max_q  <= pwdata[LIMIT_W-1:0];
				REG_Y_MAX:  y_max_q  <= pwdata[LIMIT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ENABLE: prdata = DATA_W'(enable_q);
			REG_X_MAX:  prdata = DATA_W'(x_max_q);
			REG_Y_MAX:  prdata = DATA_W'(y_max_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.enable = enable_q;
	assign cfg.x_max  = x_max_q;
	assign cfg.y_max  = y_max_q;

endmodule

>>> hw/rtl/pmt_core.sv
// ----------------------------------------------------------------------------
// pmt_core: packet assembly and cursor update
// Holds the packet phase, the stored flags and dx bytes, the cursor position
// and the buttons, and computes the result for the byte being stepped.
// ----------------------------------------------------------------------------
module pmt_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [pmt_pkg::BYTE_W-1:0] data,
	input  pmt_pkg::cfg_t              cfg,
	output pmt_pkg::res_t              res
);
	import pmt_pkg::*;

	// Signed working width: room for the larger of position and limit plus a
	// carry and a sign bit.
	localparam int SW = ((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W) + 2;
	localparam logic [SW-1:0] CAP = SW'((1 << COORD_BITS) - 1);

	phase_t                  phase_q, phase_d;
	logic [BYTE_W-1:0]       flags_q;
	logic [BYTE_W-1:0]       dx_q;
	logic [COORD_BITS-1:0]   pos_x_q, pos_x_d;
	logic [COORD_BITS-1:0]   pos_y_q, pos_y_d;
	logic [BTN_W-1:0]        btn_q, btn_d;
	logic                    done;
	logic signed [SW-1:0]    nx, ny;
	logic [SW-1:0]           top_x, top_y;
	logic [SW-1:0]           cx, cy;
	logic [15:0]             x_ext, y_ext;

	// Limit capped at the largest coordinate the position can hold
	assign top_x = (SW'(cfg.x_max) < CAP) ? SW'(cfg.x_max) : CAP;
	assign top_y = (SW'(cfg.y_max) < CAP) ? SW'(cfg.y_max) : CAP;

	// Screen Y grows downward, so dy is subtracted.
	assign nx = signed'(SW'(pos_x_q)) + SW'(signed'(dx_q));
	assign ny = signed'(SW'(pos_y_q)) - SW'(signed'(data));

	always_comb begin
		if (nx < 0) cx = '0;
		else if (unsigned'(nx) > top_x) cx = top_x;
		else cx = unsigned'(nx);
		if (ny < 0) cy = '0;
		else if (unsigned'(ny) > top_y) cy = top_y;
		else cy = unsigned'(ny);
	end

	always_comb begin
		phase_d = phase_q;
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		btn_d   = btn_q;
		done    = 1'b0;
		if (cfg.enable) begin
			unique case (phase_q)
				PH_FLAGS: phase_d = PH_DX;
				PH_DX:    phase_d = PH_DY;
				PH_DY: begin
					phase_d = PH_FLAGS;
					pos_x_d = COORD_BITS'(cx);
					pos_y_d = COORD_BITS'(cy);
					btn_d   = BTN_W'(flags_q & BTN_MASK);
					done    = 1'b1;
				end
				default:  phase_d = PH_FLAGS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			flags_q <= '0;
			dx_q    <= '0;
			pos_x_q <= COORD_BITS'(POS_X_RESET);
			pos_y_q <= COORD_BITS'(POS_Y_RESET);
			btn_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
			btn_q   <= btn_d;
			if (cfg.enable && phase_q == PH_FLAGS) flags_q <= data;
			if (cfg.enable && phase_q == PH_DX)    dx_q    <= data;
		end
	end

	assign x_ext = 16'(pos_x_d);
	assign y_ext = 16'(pos_y_d);

	assign res.packet_done = done;
	assign res.cursor_x    = x_ext[OUT_W-1:0];
	assign res.cursor_y    = y_ext[OUT_W-1:0];
	assign res.button_bits = btn_d;

endmodule

>>> hw/rtl/pmt_checker.sv
// ----------------------------------------------------------------------------
// pmt_checker: port-level checks of the packet tracker
// Watches the top level's ports and checks hold, latency and state rules.
// ----------------------------------------------------------------------------
module pmt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       packet_done,
	input logic [pmt_pkg::OUT_W-1:0]  cursor_x,
	input logic [pmt_pkg::OUT_W-1:0]  cursor_y,
	input logic [pmt_pkg::BTN_W-1:0]  button_bits
);
	import pmt_pkg::*;

	logic in_xfer;
	logic out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_done) &&
		$stable(cursor_x) && $stable(cursor_y) && $stable(button_bits))
		else $error("stalled result changed");

	// The input stalls only when both registers are full and the output waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a full pipeline");

	// An empty pipeline shows a result once a byte has passed through the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_xfer, 2))
		else $error("result appeared without a byte two cycles earlier");

	// Position and buttons change only with a completed packet.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && $past(out_xfer) && !packet_done |->
		$stable(cursor_x) && $stable(cursor_y) && $stable(button_bits))
		else $error("cursor changed without a completed packet");

endmodule

bind ps2_mouse_packet_tracker pmt_checker u_pmt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.packet_done (packet_done),
	.cursor_x    (cursor_x),
	.cursor_y    (cursor_y),
	.button_bits (button_bits)
);

>>> tb/sv/pmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_result_checker: result checker for the PS/2 mouse packet tracker
// Follows register writes and byte transfers, keeps its own packet phase,
// cursor position and button state, and compares every result transfer with
// the oldest expectation. Counts failures, packets and clamped updates.
// ----------------------------------------------------------------------------
module pmt_result_checker #(
	parameter int COORD_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [pmt_pkg::ADDR_W-1:0] paddr,
	input  logic [pmt_pkg::DATA_W-1:0] pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [pmt_pkg::BYTE_W-1:0] data_byte,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       packet_done,
	input  logic [pmt_pkg::OUT_W-1:0]  cursor_x,
	input  logic [pmt_pkg::OUT_W-1:0]  cursor_y,
	input  logic [pmt_pkg::BTN_W-1:0]  button_bits,
	output int                         n_fail,
	output int                         n_pending,
	output int                         n_bytes,
	output int                         n_packets,
	output int                         n_clamps
);
	import pmt_pkg::*;

	localparam int COORD_TOP = (1 << COORD_BITS) - 1;

	logic                  cfg_enable;
	logic [LIMIT_W-1:0]    cfg_x_max;
	logic [LIMIT_W-1:0]    cfg_y_max;
	phase_t                phase;
	logic [BYTE_W-1:0]     flags_hold;
	logic [BYTE_W-1:0]     dx_hold;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [BTN_W-1:0]      buttons;
	res_t                  expected_q[$];
	res_t                  got;
	res_t                  want;

	// The lower limit is zero; the upper one is the register, capped to the
	// stored coordinate width.
	function automatic int clamp_coord(input int v, input logic [LIMIT_W-1:0] lim);
		int top;
		top = (int'(lim) < COORD_TOP) ? int'(lim) : COORD_TOP;
		if (v < 0)
			return 0;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic res_t track_byte(input logic [BYTE_W-1:0] b);
		res_t r;
		int   nx;
		int   ny;
		r.packet_done = 1'b0;
		if (cfg_enable) begin
			unique case (phase)
				PH_FLAGS: begin
					flags_hold = b;
					phase = PH_DX;
				end
				PH_DX: begin
					dx_hold = b;
					phase = PH_DY;
				end
				PH_DY: begin
					nx = int'(pos_x) + int'($signed(dx_hold));
					ny = int'(pos_y) - int'($signed(b));
					pos_x = COORD_BITS'(clamp_coord(nx, cfg_x_max));
					pos_y = COORD_BITS'(clamp_coord(ny, cfg_y_max));
					if (int'(pos_x) != nx || int'(pos_y) != ny)
						n_clamps++;
					buttons = flags_hold[BTN_W-1:0];
					phase = PH_FLAGS;
					r.packet_done = 1'b1;
					n_packets++;
				end
				default: phase = PH_FLAGS;
			endcase
		end
		r.cursor_x = pos_x[OUT_W-1:0];
		r.cursor_y = pos_y[OUT_W-1:0];
		r.button_bits = buttons;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_enable = 1'b0;
			cfg_x_max = X_MAX_RESET;
			cfg_y_max = Y_MAX_RESET;
			phase = PH_FLAGS;
			flags_hold = '0;
			dx_hold = '0;
			pos_x = COORD_BITS'(POS_X_RESET);
			pos_y = COORD_BITS'(POS_Y_RESET);
			buttons = '0;
			expected_q.delete();
			n_fail = 0;
			n_bytes = 0;
			n_packets = 0;
			n_clamps = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				unique case (paddr[ADDR_W-1:2])
					REG_ENABLE: cfg_enable = pwdata[0];
					REG_X_MAX:  cfg_x_max = pwdata[LIMIT_W-1:0];
					REG_Y_MAX:  cfg_y_max = pwdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {packet_done, cursor_x, cursor_y, button_bits};
				if (expected_q.size() == 0) begin
					if (n_fail < 10)
						$display({"%0t: result with no byte outstanding: ",
							"done=%0d x=%0d y=%0d buttons=%0h"},
							$realtime, got.packet_done, got.cursor_x, got.cursor_y,
							got.button_bits);
					n_fail++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (n_fail < 10)
							$display({"%0t: result mismatch: expected done=%0d x=%0d ",
								"y=%0d buttons=%0h, got done=%0d x=%0d y=%0d ",
								"buttons=%0h"},
								$realtime, want.packet_done, want.cursor_x, want.cursor_y,
								want.button_bits, got.packet_done, got.cursor_x,
								got.cursor_y, got.button_bits);
						n_fail++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_q.push_back(track_byte(data_byte));
				n_bytes++;
			end
		end
		n_pending <= expected_q.size();
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the PS/2 mouse packet tracker
// Drives mouse bytes in random bursts against a randomly stalling result
// side, steps through many clamp limit and enable settings, and leaves the
// checking to pmt_result_checker, which sits beside the block.
// ----------------------------------------------------------------------------
module tb;
	import pmt_pkg::*;

	localparam int COORD_BITS  = 12;
	localparam int ITEM_TARGET = 1950;

	// Directed packets, three bytes each: no movement with the sync bit set,
	// the largest positive deltas (Y clamps at zero), X against its upper limit,
	// the most negative deltas (Y clamps at its upper limit), a dy of minus
	// one, X clamping at zero, and a flags byte with only its upper bits set.
	localparam logic [BYTE_W-1:0] DIRECTED_BYTES [21] = '{
		8'h08, 8'h00, 8'h00,
		8'hFF, 8'h7F, 8'h7F,
		8'h01, 8'h7F, 8'h80,
		8'h02, 8'h80, 8'h80,
		8'h04, 8'h80, 8'hFF,
		8'h07, 8'h80, 8'h01,
		8'hF8, 8'h01, 8'h00
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              packet_done;
	logic [OUT_W-1:0]  cursor_x;
	logic [OUT_W-1:0]  cursor_y;
	logic [BTN_W-1:0]  button_bits;

	int n_fail;
	int n_pending;
	int n_bytes;
	int n_packets;
	int n_clamps;

	// Sender burst bookkeeping and receiver stall pattern.
	int burst_left = 1;
	int stall_mode = 0;
	int mode_left = 0;

	int items_sent = 0;
	int setting_no = 0;

	always #6 clk = ~clk;

	ps2_mouse_packet_tracker #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packet_done(packet_done),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.button_bits(button_bits)
	);

	pmt_result_checker #(
		.COORD_BITS(COORD_BITS)
	) u_pmt_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packet_done(packet_done),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.button_bits(button_bits),
		.n_fail     (n_fail),
		.n_pending  (n_pending),
		.n_bytes    (n_bytes),
		.n_packets  (n_packets),
		.n_clamps   (n_clamps)
	);

	// A hung handshake must not leave the run going for ever. The bound is
	// many times the slowest legal run, which has every result held by the
	// heaviest stall mode and every byte followed by the longest sender gap.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// The result side switches at random between four behaviours: never
	// stalling, stalling now and then, stalling half the time, or stalling
	// almost always, so that back-pressure lands on every pipeline state.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left <= $urandom_range(20, 200);
			stall_mode <= $urandom_range(0, 3);
		end else begin
			mode_left <= mode_left - 1;
		end
		unique case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// One register write: a setup cycle, then an access cycle that completes
	// when pready is high, then a quiet cycle so that back-to-back writes never
	// lower and raise psel within the same time step.
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one byte and holds it until the transfer takes place. At the end
	// of a burst the sender may drop valid for a random gap; a gap of zero
	// simply joins two bursts into one longer stretch without idling.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// The sender stops and waits until every byte it has sent has been
	// answered. Every byte gives a result, so the block is idle after that.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
	endtask

	// Registers are only written with nothing in flight.
	task automatic apply_settings(input logic en, input int xm, input int ym);
		wait_drained();
		cfg_write(REG_X_MAX, DATA_W'(xm));
		cfg_write(REG_Y_MAX, DATA_W'(ym));
		cfg_write(REG_ENABLE, DATA_W'(en));
	endtask

	// A movement byte: fully random, a large step in the chosen direction so
	// that the cursor drifts towards one edge, or a small jitter around zero.
	function automatic logic [BYTE_W-1:0] pick_delta(input bit up);
		unique case ($urandom_range(0, 2))
			0:       return BYTE_W'($urandom_range(0, 255));
			1:       return up ? BYTE_W'($urandom_range(8'h60, 8'h7F))
			               : BYTE_W'($urandom_range(8'h80, 8'hA0));
			default: return BYTE_W'($urandom_range(0, 8) - 4);
		endcase
	endfunction

	initial begin
		int  xm;
		int  ym;
		bit  en;
		bit  up_x;
		bit  up_y;
		int  n_pkts;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the block is disabled: these transfers must
		// come back with the reset position and no packet completed.
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);

		apply_settings(1'b1, int'(X_MAX_RESET), int'(Y_MAX_RESET));
		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i]);

		// Random part. The first settings pin both limits to the extremes; the
		// second one is long and drifts right and down so that the cursor
		// really reaches the top of the coordinate range. After that, limits
		// are random, often tiny so that clamping is frequent. Every sixth
		// setting disables the block, which leaves any half-received packet
		// pending until the block is enabled again. Some phases end with one
		// or two stray bytes, which shift the packet framing from then on.
		while (items_sent < ITEM_TARGET) begin
			unique case (setting_no)
				0: begin xm = 0; ym = 0; end
				1: begin xm = 4095; ym = 4095; end
				2: begin xm = 4095; ym = 0; end
				3: begin xm = 0; ym = 4095; end
				default: begin
					xm = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
					ym = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
				end
			endcase
			en = (setting_no % 6 != 5);
			apply_settings(en, xm, ym);
			if (!en) begin
				repeat ($urandom_range(3, 12))
					send_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				up_x = $urandom_range(0, 1);
				up_y = $urandom_range(0, 1);
				n_pkts = $urandom_range(10, 50);
				if (setting_no == 1) begin
					up_x = 1'b1;
					up_y = 1'b0;
					n_pkts = 150;
				end
				repeat (n_pkts) begin
					send_byte(BYTE_W'($urandom_range(0, 255)));
					send_byte(pick_delta(up_x));
					send_byte(pick_delta(up_y));
					items_sent += 3;
				end
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 2)) begin
						send_byte(BYTE_W'($urandom_range(0, 255)));
						items_sent++;
					end
				end
			end
			setting_no++;
		end

		// Let the last results arrive, then keep the clock running in case the
		// block produces anything it should not.
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Run covered %0d byte transfers and %0d completed packets over %0d settings.",
			n_bytes, n_packets, setting_no + 1);
		$display("%0d packets hit a clamp limit; %0d results disagreed with the prediction.",
			n_clamps, n_fail);
		if (n_fail == 0 && n_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
